FILE: design/olir_pkg.sv
package olir_pkg;

   // built list depth and derived widths
   localparam int DEPTH    = 16;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   // field widths
   localparam int FUNC_W   = 2;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 5;
   localparam int COUNT_W  = 5;

   // width for comparing count, position and capacity
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   // csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // operation codes
   typedef logic [FUNC_W-1:0] func_type;
   localparam func_type FUNC_INSERT = 2'd0;
   localparam func_type FUNC_REMOVE = 2'd1;
   localparam func_type FUNC_READ   = 2'd2;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BOUNDS = 2'd3
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic exec;
   } cmd_type;

endpackage

FILE: design/olir_datapath.sv
module olir_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  olir_pkg::cmd_type                     cmd,
   input  logic [olir_pkg::FUNC_W-1:0]           req_func,
   input  logic [olir_pkg::POS_W-1:0]            req_position,
   input  logic signed [olir_pkg::DATA_W-1:0]    req_value,
   input  logic [olir_pkg::CAP_W-1:0]            capacity,
   output logic [olir_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [olir_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [olir_pkg::COUNT_W-1:0]          rsp_entry_count,
   output logic                                  rsp_empty_flag
);

   // list storage and count
   logic signed [olir_pkg::DATA_W-1:0] entries_ff [olir_pkg::DEPTH];
   logic signed [olir_pkg::DATA_W-1:0] entries_in [olir_pkg::DEPTH];
   logic [olir_pkg::CNT_W-1:0]         count_ff;
   logic [olir_pkg::CNT_W-1:0]         count_in;

   // captured request
   olir_pkg::func_type                 func_ff;
   logic [olir_pkg::POS_W-1:0]         pos_ff;
   logic signed [olir_pkg::DATA_W-1:0] value_ff;

   // result word
   olir_pkg::status_type               status_ff;
   olir_pkg::status_type               status_in;
   logic signed [olir_pkg::DATA_W-1:0] rd_ff;
   logic signed [olir_pkg::DATA_W-1:0] rd_in;
   logic [olir_pkg::COUNT_W-1:0]       rsp_count_ff;
   logic                               empty_ff;

   logic [olir_pkg::CMP_W-1:0] cnt_ext;
   logic [olir_pkg::CMP_W-1:0] pos_ext;
   logic [olir_pkg::CMP_W-1:0] cap_ext;
   logic [olir_pkg::IDX_W-1:0] pos_idx;
   logic                       list_full;
   logic                       list_empty;
   logic                       do_insert;
   logic                       do_remove;

   assign cnt_ext    = olir_pkg::CMP_W'(count_ff);
   assign pos_ext    = olir_pkg::CMP_W'(pos_ff);
   assign cap_ext    = olir_pkg::CMP_W'(capacity);
   assign pos_idx    = olir_pkg::IDX_W'(pos_ff);
   assign list_empty = (count_ff == '0);
   assign list_full  = (cnt_ext >= cap_ext)
                    || (count_ff >= olir_pkg::CNT_W'(olir_pkg::DEPTH));

   // request checks and read port
   always_comb begin
      status_in = olir_pkg::ST_DONE;
      rd_in     = '0;
      do_insert = 1'b0;
      do_remove = 1'b0;
      unique case (func_ff)
         olir_pkg::FUNC_INSERT: begin
            if (list_full) begin
               status_in = olir_pkg::ST_FULL;
            end else if (pos_ext > cnt_ext) begin
               status_in = olir_pkg::ST_BOUNDS;
            end else begin
               do_insert = 1'b1;
            end
         end
         olir_pkg::FUNC_REMOVE: begin
            if (list_empty) begin
               status_in = olir_pkg::ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status_in = olir_pkg::ST_BOUNDS;
            end else begin
               do_remove = 1'b1;
            end
         end
         olir_pkg::FUNC_READ: begin
            if (list_empty) begin
               status_in = olir_pkg::ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status_in = olir_pkg::ST_BOUNDS;
            end else begin
               rd_in = entries_ff[pos_idx];
            end
         end
         default: begin
            status_in = olir_pkg::ST_DONE;
         end
      endcase
   end

   // shift chain: the entries from the position on move up or down in one step
   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      if (do_insert) begin
         for (int i = 1; i < olir_pkg::DEPTH; i++) begin
            if (olir_pkg::CMP_W'(i) > pos_ext) begin
               entries_in[i] = entries_ff[i-1];
            end
         end
         for (int i = 0; i < olir_pkg::DEPTH; i++) begin
            if (olir_pkg::CMP_W'(i) == pos_ext) begin
               entries_in[i] = value_ff;
            end
         end
         count_in = count_ff + olir_pkg::CNT_W'(1);
      end else if (do_remove) begin
         for (int i = 0; i < olir_pkg::DEPTH - 1; i++) begin
            if (olir_pkg::CMP_W'(i) >= pos_ext) begin
               entries_in[i] = entries_ff[i+1];
            end
         end
         count_in = count_ff - olir_pkg::CNT_W'(1);
      end
   end

   // list state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         entries_ff <= entries_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff  <= req_func;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff    <= status_in;
         rd_ff        <= rd_in;
         rsp_count_ff <= olir_pkg::COUNT_W'(count_in);
         empty_ff     <= (count_in == '0);
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_read_value  = rd_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_empty_flag  = empty_ff;

endmodule

FILE: design/olir_ctrl.sv
module olir_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output olir_pkg::cmd_type cmd
);

   typedef enum logic {
      IDLE,
      EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // output register can take a word this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready    = (state_ff == IDLE);
   assign cmd.load_req = req_valid && (state_ff == IDLE);
   assign cmd.exec     = (state_ff == EXEC) && out_free;

   // next state and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               state_in = EXEC;
            end
         end
         EXEC: begin
            if (out_free) begin
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/ordered_list_insert_remove.sv
// Bounded ordered list of signed 32-bit words, up to 16 entries.
// Request channel (req_*): func selects insert, remove or read at req_position;
// req_value is the word to insert. Every request gives exactly one response.
// Response channel (rsp_*): status, the word read (zero unless a good read),
// the entry count after the operation and an empty flag.
// Timing: an accepted request is captured, then executed as soon as the output
// register is free, and its response is registered at execution; a new request
// is taken only after the last one has executed, set by the two-state controller
// (capture, then execute on a shift chain that moves the affected entries at once).
// A stalled response stays in the output register while the next request is
// accepted; that request executes as soon as the response is taken.
// csr_* port: register 0 at byte address 0 is list_capacity (5 bits), the
// most entries that inserts may fill; pready is always high.
// Reset (synchronous, active high) empties the list and sets list_capacity to
// 16; entry contents are not cleared, entries above the count are never read.
module ordered_list_insert_remove (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [olir_pkg::FUNC_W-1:0]          req_func,
   input  logic [olir_pkg::POS_W-1:0]           req_position,
   input  logic signed [olir_pkg::DATA_W-1:0]   req_value,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [olir_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [olir_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [olir_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic                                 rsp_empty_flag,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [olir_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [olir_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [olir_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   olir_pkg::cmd_type            cmd;
   logic [olir_pkg::CAP_W-1:0]   capacity_ff;
   logic [olir_pkg::CAP_W-1:0]   capacity_in;
   logic                         cap_sel;

   // capacity register
   assign cap_sel    = (csr_paddr[2] == olir_pkg::CSR_IDX_CAPACITY);
   assign csr_pready = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && cap_sel) begin
         capacity_in = csr_pwdata[olir_pkg::CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= olir_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign csr_prdata = cap_sel ? olir_pkg::CSR_DATA_W'(capacity_ff) : '0;

   olir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   olir_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_value       (req_value),
      .capacity        (capacity_ff),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_empty_flag  (rsp_empty_flag)
   );

endmodule

FILE: design/olir_checker.sv
module olir_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [olir_pkg::STATUS_W-1:0]        rsp_status,
   input  logic signed [olir_pkg::DATA_W-1:0]   rsp_read_value,
   input  logic [olir_pkg::COUNT_W-1:0]         rsp_entry_count,
   input  logic                                 rsp_empty_flag
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("response word changed while stalled");

   // one request in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on back-to-back cycles");

   // empty flag follows the entry count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_flag == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   // a refused request reads as zero
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != olir_pkg::ST_DONE) |-> (rsp_read_value == '0))
      else $error("nonzero read value on a refused request");

endmodule

bind ordered_list_insert_remove olir_checker u_olir_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_read_value  (rsp_read_value),
   .rsp_entry_count (rsp_entry_count),
   .rsp_empty_flag  (rsp_empty_flag)
);
